FILE: rtl/madac_pkg.sv
// ----------------------------------------------------------------------------
// madac_pkg
// Shared types and constants for the mesh angle-deficit accumulator.
// ----------------------------------------------------------------------------
package madac_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TRI  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // one node position, x in [0], y in [1], z in [2] (Q16.16 each)
    typedef logic [2:0][31:0] pos_t;
    // three corner angles, Q8.24
    typedef logic [2:0][31:0] ang_set_t;

    typedef struct packed {
        logic done;
        logic degen;
    } tri_stat_t;

    localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
    localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414357;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

    // CORDIC arctangent of 2^-i, Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/madac_ram.sv
// ----------------------------------------------------------------------------
// madac_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module madac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/madac_tri.sv
// ----------------------------------------------------------------------------
// madac_tri
// Triangle corner-angle engine: sides, normalisation, lengths, unit vectors,
// cosines and CORDIC acos, all on one shared multiplier.
// ----------------------------------------------------------------------------
module madac_tri #(
    parameter int ACOS_ITERATIONS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  madac_pkg::pos_t       vtx [3],
    output madac_pkg::tri_stat_t  stat,
    output madac_pkg::ang_set_t   ang
);

    import madac_pkg::*;

    localparam int         CORD_N    = (ACOS_ITERATIONS > 32) ? 32 : ACOS_ITERATIONS;
    localparam logic [4:0] CORD_LAST = 5'(CORD_N - 1);

    typedef enum logic [3:0] {
        E_IDLE, E_SIDE, E_CHK, E_NORM, E_SQ, E_SQRT, E_LEN, E_DIVI, E_DIV,
        E_DOT, E_COS, E_CSQ, E_SQI, E_PRE, E_CORD, E_ANG
    } eng_state_t;

    eng_state_t               state_reg;
    logic                     phase_reg;      // 0: side lengths, 1: corner angles
    logic [1:0]               k_reg;
    logic [1:0]               j_reg;
    logic [4:0]               cnt_reg;
    logic [32:0]              mag_reg [9];
    logic                     neg_reg [9];
    logic [32:0]              m_reg;
    logic [5:0]               down_reg;
    logic [5:0]               up_reg;
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       acc_reg;
    logic [63:0]              sv_reg;
    logic [63:0]              sr_reg;
    logic [30:0]              len_reg;
    logic [31:0]              rem_reg;
    logic [30:0]              quo_reg;
    logic signed [31:0]       u_reg [9];
    logic signed [31:0]       c_reg;
    logic signed [33:0]       cx_reg;
    logic signed [33:0]       cy_reg;
    logic signed [34:0]       cz_reg;
    ang_set_t                 ang_reg;
    logic                     done_reg;
    logic                     degen_reg;

    function automatic logic [3:0] cidx(input logic [1:0] k, input logic [1:0] j);
        logic [1:0] jj;
        jj = (j == 2'd3) ? 2'd0 : j;
        return 4'(k * 3 + jj);
    endfunction

    // combinational datapath
    logic [1:0]         nxt_k;
    logic [1:0]         p0;
    logic signed [32:0] diff;
    logic [32:0]        magn;
    logic [3:0]         mg_idx;
    logic [32:0]        mg_sh;
    logic [29:0]        mg_val;
    logic [63:0]        bitv;
    logic [63:0]        tst;
    logic [32:0]        r2;
    logic               qbit;
    logic [30:0]        q_fin;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_next;
    logic signed [63:0] cos_t;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [34:0] atan_v;
    logic signed [34:0] zc;
    logic signed [34:0] zr;

    always_comb
    begin
        nxt_k  = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
        p0     = (k_reg == 2'd0) ? 2'd2 : k_reg - 2'd1;
        diff   = {vtx[nxt_k][j_reg][31], vtx[nxt_k][j_reg]}
               - {vtx[k_reg][j_reg][31], vtx[k_reg][j_reg]};
        magn   = diff[32] ? 33'(-diff) : 33'(diff);

        mg_idx = (state_reg == E_SQ) ? cidx(k_reg, cnt_reg[1:0]) : cidx(k_reg, j_reg);
        mg_sh  = (mag_reg[mg_idx] >> down_reg) << up_reg;
        mg_val = mg_sh[29:0];

        // restoring square root step
        bitv   = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        tst    = sr_reg + bitv;

        // restoring division step; the first step shifts in the last numerator bit
        r2     = {rem_reg, (cnt_reg == 5'd0) ? mg_val[0] : 1'b0};
        qbit   = (r2 >= {2'b00, len_reg});
        q_fin  = {quo_reg[29:0], qbit};

        case (state_reg)
            E_SQ:
            begin
                mul_a = $signed({2'b00, mg_val});
                mul_b = $signed({2'b00, mg_val});
            end
            E_DOT:
            begin
                mul_a = u_reg[cidx(p0, cnt_reg[1:0])];
                mul_b = u_reg[cidx(k_reg, cnt_reg[1:0])];
            end
            default:
            begin
                mul_a = c_reg;
                mul_b = c_reg;
            end
        endcase
        prod_next = mul_a * mul_b;

        cos_t  = (64'sd536870912 - acc_reg) >>> 30;

        xs     = cx_reg >>> cnt_reg;
        ys     = cy_reg >>> cnt_reg;
        atan_v = $signed({3'b000, atan_q30(cnt_reg)});

        if (cz_reg < 35'sd0)
        begin
            zc = 35'sd0;
        end
        else if (cz_reg > PI_Q30)
        begin
            zc = PI_Q30;
        end
        else
        begin
            zc = cz_reg;
        end
        zr = zc + 35'sd32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            degen_reg <= 1'b0;
            phase_reg <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= ((state_reg == E_CHK) && (m_reg == '0))
                     || ((state_reg == E_LEN) && (sr_reg == '0))
                     || ((state_reg == E_ANG) && (k_reg == 2'd2));
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= '0;
                        j_reg     <= '0;
                        m_reg     <= '0;
                        down_reg  <= '0;
                        up_reg    <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= E_SIDE;
                    end
                end
                E_SIDE:
                begin
                    mag_reg[cidx(k_reg, j_reg)] <= magn;
                    neg_reg[cidx(k_reg, j_reg)] <= diff[32];
                    if (magn > m_reg)
                    begin
                        m_reg <= magn;
                    end
                    if (j_reg == 2'd2)
                    begin
                        j_reg <= '0;
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= E_CHK;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                E_CHK:
                begin
                    if (m_reg == '0)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        state_reg <= E_NORM;
                    end
                end
                E_NORM:
                begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (m_reg[32:30] != 3'd0)
                    begin
                        m_reg    <= m_reg >> 1;
                        down_reg <= down_reg + 6'd1;
                    end
                    else if (!m_reg[29])
                    begin
                        m_reg  <= m_reg << 1;
                        up_reg <= up_reg + 6'd1;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        j_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= E_SQ;
                    end
                end
                E_SQ, E_DOT:
                begin
                    prod_reg <= prod_next;
                    acc_reg  <= (cnt_reg == 5'd0) ? 64'sd0 : acc_reg + prod_reg;
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg <= '0;
                        if (state_reg == E_SQ)
                        begin
                            sv_reg    <= 64'(acc_reg + prod_reg);
                            sr_reg    <= '0;
                            state_reg <= E_SQRT;
                        end
                        else
                        begin
                            state_reg <= E_COS;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                E_SQRT:
                begin
                    if (sv_reg >= tst)
                    begin
                        sv_reg <= sv_reg - tst;
                        sr_reg <= (sr_reg >> 1) + bitv;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                    if (cnt_reg == 5'd31)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= phase_reg ? E_PRE : E_LEN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                E_LEN:
                begin
                    if (sr_reg == '0)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        len_reg   <= sr_reg[30:0];
                        j_reg     <= '0;
                        state_reg <= E_DIVI;
                    end
                end
                E_DIVI:
                begin
                    rem_reg   <= {3'b000, mg_val[29:1]};
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= E_DIV;
                end
                E_DIV:
                begin
                    rem_reg <= qbit ? 32'(r2 - {2'b00, len_reg}) : r2[31:0];
                    quo_reg <= q_fin;
                    if (cnt_reg == 5'd30)
                    begin
                        u_reg[cidx(k_reg, j_reg)] <= neg_reg[cidx(k_reg, j_reg)]
                                                   ? -$signed({1'b0, q_fin})
                                                   : $signed({1'b0, q_fin});
                        cnt_reg <= '0;
                        if (j_reg != 2'd2)
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= E_DIVI;
                        end
                        else if (k_reg != 2'd2)
                        begin
                            k_reg     <= k_reg + 2'd1;
                            j_reg     <= '0;
                            state_reg <= E_SQ;
                        end
                        else
                        begin
                            k_reg     <= '0;
                            phase_reg <= 1'b1;
                            state_reg <= E_DOT;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                E_COS:
                begin
                    if (cos_t > ONE_Q30)
                    begin
                        c_reg <= 32'(ONE_Q30);
                    end
                    else if (cos_t < -ONE_Q30)
                    begin
                        c_reg <= 32'(-ONE_Q30);
                    end
                    else
                    begin
                        c_reg <= 32'(cos_t);
                    end
                    state_reg <= E_CSQ;
                end
                E_CSQ:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= E_SQI;
                end
                E_SQI:
                begin
                    sv_reg    <= (64'd1 << 60) - 64'(prod_reg);
                    sr_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= E_SQRT;
                end
                E_PRE:
                begin
                    // a negative cosine starts a quarter turn on
                    if (c_reg < 32'sd0)
                    begin
                        cx_reg <= $signed({3'b000, sr_reg[30:0]});
                        cy_reg <= -{{2{c_reg[31]}}, c_reg};
                        cz_reg <= HALF_PI_Q30;
                    end
                    else
                    begin
                        cx_reg <= {{2{c_reg[31]}}, c_reg};
                        cy_reg <= $signed({3'b000, sr_reg[30:0]});
                        cz_reg <= 35'sd0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= E_CORD;
                end
                E_CORD:
                begin
                    if (!cy_reg[33])
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_v;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_v;
                    end
                    if (cnt_reg == CORD_LAST)
                    begin
                        state_reg <= E_ANG;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                E_ANG:
                begin
                    ang_reg[k_reg] <= {3'b000, zr[34:6]};
                    cnt_reg        <= '0;
                    if (k_reg == 2'd2)
                    begin
                        degen_reg <= 1'b0;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= E_DOT;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign stat.done  = done_reg;
    assign stat.degen = degen_reg;
    assign ang        = ang_reg;

endmodule

FILE: rtl/mesh_angle_deficit_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_angle_deficit_accumulator
// Node table with per-node angle deficits; triangles subtract corner angles.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tuser action; s_tdata node and triangle fields
// m_*      out  m_tvalid/m_tready   m_tdata read_index, deficit, degenerate_seen
// cfg_*    in   cfg_valid/cfg_ready cfg_data node_count
//
// A load writes both stores at its handshake; a read passes T_RD and T_ROUT, plus any wait on the result register.
// A triangle runs in the shared unit in madac_tri: normalising shifts, then per
// side a 32-step square root and three 31-step divides, per corner a 32-step square
// root and ACOS_ITERATIONS (at most 32) CORDIC steps.
// s_tready is low while an item is in work.
// Reset clears control, the fault flag and sets node_count to 1024; the node
// stores are not cleared. A waiting result holds in m_tdata until m_tready.
// ----------------------------------------------------------------------------
module mesh_angle_deficit_accumulator #(
    parameter int MAX_NODES       = 1024,
    parameter int ACOS_ITERATIONS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // node_index, pos_x, pos_y, pos_z, on_boundary, corner_a, corner_b, corner_c
    input  logic [143:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_index, deficit, degenerate_seen
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data
);

    import madac_pkg::*;

    localparam int          AW      = $clog2(MAX_NODES);
    localparam logic [16:0] LIM_MAX = 17'(MAX_NODES);

    typedef enum logic [2:0] {
        T_IDLE, T_RD, T_ROUT, T_TRD, T_TWAIT, T_TUPR, T_TUPW
    } top_state_t;

    top_state_t         state_reg;
    logic [10:0]        node_count_reg;
    logic               fault_reg;
    logic [9:0]         tri_idx_reg [3];
    pos_t               vtx_reg [3];
    logic [1:0]         k_reg;
    logic [1:0]         cnt_reg;
    logic               start_reg;
    logic [9:0]         rd_idx_reg;
    logic               rd_bad_reg;
    logic [31:0]        rd_def_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;

    action_t            action;
    logic [9:0]         node_index;
    logic [9:0]         corner [3];
    logic [16:0]        lim;
    logic               s_xfer;
    logic               ni_ok;
    logic               tri_ok;

    logic               pos_we;
    logic [AW-1:0]      pos_raddr;
    logic [95:0]        pos_rdata;
    logic               def_we;
    logic [AW-1:0]      def_waddr;
    logic [31:0]        def_wdata;
    logic [AW-1:0]      def_raddr;
    logic [31:0]        def_rdata;

    tri_stat_t          tri_stat;
    ang_set_t           tri_ang;

    logic signed [32:0] sub_r;
    logic [31:0]        sub_sat;

    assign action     = action_t'(s_tuser);
    assign node_index = s_tdata[9:0];
    assign corner[0]  = s_tdata[116:107];
    assign corner[1]  = s_tdata[126:117];
    assign corner[2]  = s_tdata[136:127];

    assign lim    = ({6'd0, node_count_reg} < LIM_MAX) ? {6'd0, node_count_reg} : LIM_MAX;
    assign ni_ok  = {7'd0, node_index} < lim;
    assign tri_ok = ({7'd0, corner[0]} < lim) && ({7'd0, corner[1]} < lim)
                 && ({7'd0, corner[2]} < lim);

    assign s_tready  = (state_reg == T_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // saturating subtract of the corner angle
    assign sub_r   = {def_rdata[31], def_rdata} - {tri_ang[k_reg][31], tri_ang[k_reg]};
    assign sub_sat = (sub_r[32] != sub_r[31]) ? (sub_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                              : sub_r[31:0];

    always_comb
    begin
        pos_we    = s_xfer && (action == ACT_LOAD) && ni_ok;
        pos_raddr = AW'(tri_idx_reg[cnt_reg == 2'd3 ? 2'd0 : cnt_reg]);
        def_we    = 1'b0;
        def_waddr = AW'(node_index);
        def_wdata = s_tdata[106] ? PI_Q24 : TWO_PI_Q24;
        def_raddr = AW'(node_index);
        case (state_reg)
            T_IDLE:
            begin
                def_we = pos_we;
            end
            T_TUPR:
            begin
                def_raddr = AW'(tri_idx_reg[k_reg]);
            end
            T_TUPW:
            begin
                def_we    = 1'b1;
                def_waddr = AW'(tri_idx_reg[k_reg]);
                def_wdata = sub_sat;
            end
            default:
            begin
                def_we = 1'b0;
            end
        endcase
    end

    madac_ram #(.WIDTH(96), .DEPTH(MAX_NODES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (AW'(node_index)),
        .wdata (s_tdata[105:10]),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    madac_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_def_ram (
        .clk   (clk),
        .we    (def_we),
        .waddr (def_waddr),
        .wdata (def_wdata),
        .raddr (def_raddr),
        .rdata (def_rdata)
    );

    madac_tri #(.ACOS_ITERATIONS(ACOS_ITERATIONS)) u_tri (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .vtx   (vtx_reg),
        .stat  (tri_stat),
        .ang   (tri_ang)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            node_count_reg <= 11'd1024;
            fault_reg      <= 1'b0;
            start_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            k_reg          <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            start_reg <= (state_reg == T_TRD) && (cnt_reg == 2'd3);
            if ((state_reg == T_ROUT) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (s_xfer)
                    begin
                        case (action)
                            ACT_LOAD:
                            begin
                                if (!ni_ok)
                                begin
                                    fault_reg <= 1'b1;
                                end
                            end
                            ACT_TRI:
                            begin
                                if (!tri_ok)
                                begin
                                    fault_reg <= 1'b1;
                                end
                                else
                                begin
                                    tri_idx_reg <= corner;
                                    cnt_reg     <= '0;
                                    state_reg   <= T_TRD;
                                end
                            end
                            ACT_READ:
                            begin
                                rd_idx_reg <= node_index;
                                rd_bad_reg <= !ni_ok;
                                if (!ni_ok)
                                begin
                                    fault_reg <= 1'b1;
                                end
                                state_reg <= T_RD;
                            end
                            default:
                            begin
                                state_reg <= T_IDLE;
                            end
                        endcase
                    end
                end
                T_RD:
                begin
                    rd_def_reg <= rd_bad_reg ? 32'd0 : def_rdata;
                    state_reg  <= T_ROUT;
                end
                T_ROUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {5'd0, fault_reg, rd_def_reg, rd_idx_reg};
                        state_reg    <= T_IDLE;
                    end
                end
                T_TRD:
                begin
                    // positions arrive in the cycle after their address
                    if (cnt_reg != 2'd0)
                    begin
                        vtx_reg[cnt_reg - 2'd1] <= pos_rdata;
                    end
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= T_TWAIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                T_TWAIT:
                begin
                    if (tri_stat.done)
                    begin
                        if (tri_stat.degen)
                        begin
                            fault_reg <= 1'b1;
                            state_reg <= T_IDLE;
                        end
                        else
                        begin
                            k_reg     <= '0;
                            state_reg <= T_TUPR;
                        end
                    end
                end
                T_TUPR:
                begin
                    state_reg <= T_TUPW;
                end
                T_TUPW:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= T_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= T_TUPR;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault flag cleared");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        tri_stat.done |-> (state_reg == T_TWAIT))
        else $error("triangle engine finished outside wait state");

    a_def_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        def_we |-> (state_reg == T_IDLE || state_reg == T_TUPW))
        else $error("deficit store written in wrong state");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == T_ROUT))
        else $error("result raised without a read");

endmodule
